@@ rtl/core/base64_stream_encoder_defines.svh @@
// assertion helpers used by the encoder back end
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// property checked on every clock edge outside reset
`define B64E_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define B64E_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/b64e_pkg.sv @@
package b64e_pkg;

	localparam int GC_W                = 5;
	localparam logic [GC_W-1:0] GC_MAX = 5'd31;
	localparam int DEF_GROUPS_PER_LINE = 19;
	localparam int DEF_QUEUE_DEPTH     = 4;

	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;

	// back-end character slots within one job
	localparam logic [2:0] SLOT_LAST_DATA = 3'd3;
	localparam logic [2:0] SLOT_CR        = 3'd4;
	localparam logic [2:0] SLOT_LF        = 3'd5;

	typedef enum logic {
		REG_URL_ALPHABET = 1'b0,
		REG_LINE_BREAKS  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		JOB_ONE  = 2'd0,   // one byte: two chars and two pads
		JOB_TWO  = 2'd1,   // two bytes: three chars and one pad
		JOB_FULL = 2'd2    // three bytes: four chars
	} job_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_end;
		logic       message_end;
	} out_item_t;

	typedef struct packed {
		logic [23:0] bits;
		job_kind_t   kind;
		logic        crlf;
		logic        fin;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] code, input logic url);
		logic [7:0] c;
		c = {2'b00, code};
		if (code < 6'd26) begin
			c = 8'h41 + c;
		end else if (code < 6'd52) begin
			c = 8'h61 + c - 8'd26;
		end else if (code < 6'd62) begin
			c = 8'h30 + c - 8'd52;
		end else if (code == 6'd62) begin
			c = url ? 8'h2D : 8'h2B;
		end else begin
			c = url ? 8'h5F : 8'h2F;
		end
		return c;
	endfunction

	function automatic logic [2:0] job_chars(input job_kind_t kind);
		logic [2:0] n;
		unique case (kind)
			JOB_ONE:  n = 3'd2;
			JOB_TWO:  n = 3'd3;
			default:  n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/core/b64e_front.sv @@
module b64e_front import b64e_pkg::*; #(
	parameter int GROUPS_PER_LINE = DEF_GROUPS_PER_LINE
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  in_item_t byte_data,
	input  logic     line_breaks,
	input  logic     q_full,
	output logic     push,
	output job_t     job
);

	logic [15:0]     held_bytes_q;
	logic [1:0]      held_count_q;
	logic [GC_W-1:0] group_count_q;

	logic [1:0]      cnt;
	logic            accept;
	logic            store;
	logic [GC_W-1:0] gc_inc;
	logic            crlf;

	always_comb begin
		cnt        = (held_count_q >= 2'd2) ? 2'd2 : held_count_q;
		byte_ready = !q_full;
		accept     = byte_valid && !q_full;
		store      = !byte_data.final_byte && (cnt != 2'd2);
		gc_inc     = (group_count_q == GC_MAX) ? group_count_q : group_count_q + 1'b1;
		crlf       = (cnt == 2'd2) && !byte_data.final_byte && line_breaks &&
		             (gc_inc >= GC_W'(GROUPS_PER_LINE));
		push       = accept && !store;
	end

	always_comb begin
		job.crlf = crlf;
		job.fin  = byte_data.final_byte;
		unique case (cnt)
			2'd2: begin
				job.bits = {held_bytes_q, byte_data.data_byte};
				job.kind = JOB_FULL;
			end
			2'd1: begin
				job.bits = {held_bytes_q[7:0], byte_data.data_byte, 8'h00};
				job.kind = JOB_TWO;
			end
			default: begin
				job.bits = {byte_data.data_byte, 16'h0000};
				job.kind = JOB_ONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q  <= '0;
			held_count_q  <= '0;
			group_count_q <= '0;
		end else if (accept) begin
			if (store) begin
				held_bytes_q <= {held_bytes_q[7:0], byte_data.data_byte};
				held_count_q <= cnt + 1'b1;
			end else begin
				held_bytes_q <= '0;
				held_count_q <= '0;
				if (byte_data.final_byte) begin
					group_count_q <= '0;
				end else begin
					group_count_q <= crlf ? '0 : gc_inc;
				end
			end
		end
	end

endmodule

@@ rtl/core/b64e_fifo.sv @@
module b64e_fifo import b64e_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rd_job = mem_q[rd_ptr_q];
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/b64e_back.sv @@
`include "base64_stream_encoder_defines.svh"

module b64e_back import b64e_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  logic      job_valid,
	output logic      job_pop,
	input  logic      url_alphabet,
	output logic      char_valid,
	input  logic      char_ready,
	output out_item_t char_data
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       load;
	logic [2:0] last_idx;
	logic       is_last;
	logic [5:0] sextet;
	out_item_t  next_item;

	always_comb begin
		load     = job_valid && (!out_valid_q || char_ready);
		last_idx = job.crlf ? SLOT_LF : SLOT_LAST_DATA;
		is_last  = (idx_q == last_idx);
		job_pop  = load && is_last;

		unique case (idx_q[1:0])
			2'd0:    sextet = job.bits[23:18];
			2'd1:    sextet = job.bits[17:12];
			2'd2:    sextet = job.bits[11:6];
			default: sextet = job.bits[5:0];
		endcase

		priority if (idx_q == SLOT_CR) begin
			next_item.out_char = CHAR_CR;
		end else if (idx_q == SLOT_LF) begin
			next_item.out_char = CHAR_LF;
		end else if (idx_q < job_chars(job.kind)) begin
			next_item.out_char = b64_char(sextet, url_alphabet);
		end else begin
			next_item.out_char = CHAR_PAD;
		end
		next_item.run_end     = is_last;
		next_item.message_end = is_last && job.fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_last ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_item;
		end
	end

	assign char_valid = out_valid_q;
	assign char_data  = out_q;

	// a job being walked must still sit at the head of the queue
	`B64E_ASSERT(a_idx_needs_job, (idx_q != 3'd0) |-> job_valid, "slot index set without a job")
	// only full, non-final groups may carry a line break
	`B64E_ASSERT(a_crlf_full_only, (job_valid && job.crlf) |-> (job.kind == JOB_FULL && !job.fin),
		"line break on a partial or final group")
	// line-break slots are reached only for jobs that asked for them
	`B64E_NEVER(a_slot_range, job_valid && idx_q > SLOT_LAST_DATA && !job.crlf,
		"line-break slot without line break")

endmodule

@@ rtl/core/base64_stream_encoder.sv @@
// base64 stream encoder
// byte channel (byte_valid/byte_ready/byte_data): one message byte per request,
// final_byte set on the last byte of a message; messages are never empty.
// char channel (char_valid/char_ready/char_data): one ascii character per request,
// run_end on the last character caused by a byte, message_end on the last of a message.
// apb port: register 0 at 0x0 selects the url-safe alphabet, register 1 at 0x4
// turns on cr lf after every GROUPS_PER_LINE groups; write only while idle.
// output: with the queue empty, the byte that completes a group is written into the
// queue and its first character is then loaded into the output register. the output
// register sends one character per cycle while char_ready is high: a group or a final
// partial group gives four characters (six with cr lf); a byte that only fills the hold
// register pushes no job.
// a queue of QUEUE_DEPTH group jobs sits between the byte front end and the character
// back end; byte_ready drops only while that queue is full, so a stalled receiver
// backs up into the queue and then into the byte channel with nothing lost.
// reset clears the held bytes, group counter, queue, output valid flag and both
// registers; no clearing pass is needed.
module base64_stream_encoder import b64e_pkg::*; #(
	parameter int GROUPS_PER_LINE = DEF_GROUPS_PER_LINE,
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  in_item_t    byte_data,
	output logic        char_valid,
	input  logic        char_ready,
	output out_item_t   char_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic url_alphabet_q;
	logic line_breaks_q;

	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	job_t     front_job;
	job_t     head_job;
	reg_idx_t reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_alphabet_q <= 1'b0;
			line_breaks_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_URL_ALPHABET: url_alphabet_q <= pwdata[0];
				REG_LINE_BREAKS:  line_breaks_q  <= pwdata[0];
				default:          url_alphabet_q <= url_alphabet_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_URL_ALPHABET: prdata = {31'b0, url_alphabet_q};
			REG_LINE_BREAKS:  prdata = {31'b0, line_breaks_q};
			default:          prdata = '0;
		endcase
	end

	b64e_front #(
		.GROUPS_PER_LINE(GROUPS_PER_LINE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_data   (byte_data),
		.line_breaks (line_breaks_q),
		.q_full      (q_full),
		.push        (push),
		.job         (front_job)
	);

	b64e_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.pop    (pop),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	b64e_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (head_job),
		.job_valid    (!q_empty),
		.job_pop      (pop),
		.url_alphabet (url_alphabet_q),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_data    (char_data)
	);

endmodule
